/* sv/rdq_pkg.sv */
// Package for the ring deque: sizes, operation and status codes, cell command bundle.
`timescale 1ns / 1ps

package rdq_pkg;

	localparam int DEPTH      = 64;
	localparam int DATA_WIDTH = 32;
	localparam int CNT_W      = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		OP_PUSH_BACK  = 2'd0,
		OP_PUSH_FRONT = 2'd1,
		OP_POP_BACK   = 2'd2,
		OP_POP_FRONT  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// command broadcast to every cell; at most one strobe is high
	typedef struct packed {
		logic                  push_back;
		logic                  push_front;
		logic                  pop_back;
		logic                  pop_front;
		logic [DATA_WIDTH-1:0] word;
	} cmd_t;

endpackage

/* sv/rdq_cell.sv */
// One storage cell of the deque chain: holds a word and its valid flag.
`timescale 1ns / 1ps

module rdq_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rdq_pkg::cmd_t                 cmd,
	input  logic                          left_valid,
	input  logic [rdq_pkg::DATA_WIDTH-1:0] left_data,
	input  logic                          right_valid,
	input  logic [rdq_pkg::DATA_WIDTH-1:0] right_data,
	output logic                          valid_q,
	output logic [rdq_pkg::DATA_WIDTH-1:0] data_q,
	output logic [rdq_pkg::DATA_WIDTH-1:0] back_tap
);

	logic is_last;

	// last occupied cell of the chain
	assign is_last  = valid_q && !right_valid;
	assign back_tap = is_last ? data_q : '0;

	// valid flag: shift with the chain, fill at the tail, drop at the tail
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.push_front) begin
			valid_q <= left_valid;
		end else if (cmd.pop_front) begin
			valid_q <= right_valid;
		end else if (cmd.push_back && !valid_q && left_valid) begin
			valid_q <= 1'b1;
		end else if (cmd.pop_back && is_last) begin
			valid_q <= 1'b0;
		end
	end

	// word: push front takes left, pop front right, push back cmd.word
	always_ff @(posedge clk) begin
		if (cmd.push_front) begin
			data_q <= left_data;
		end else if (cmd.pop_front) begin
			data_q <= right_data;
		end else if (cmd.push_back && !valid_q && left_valid) begin
			data_q <= cmd.word;
		end
	end

endmodule

/* sv/ring_deque_unit.sv */
// Top level of the ring deque: cell chain, count, result register and handshakes.
`timescale 1ns / 1ps

//  channel | signals                                        | direction
//  --------+------------------------------------------------+----------
//  input   | in_valid, in_ready, op, data_in                | in
//  result  | out_valid, out_ready, status, item_count_out,  | out
//          | front_word, back_word                          |
//
// One request is taken per clock while in_ready is high; its result is registered and shows in the next cycle.
// Every cell updates on the same edge, regardless of fill.
// A new request is taken while the previous result is being taken (in_ready
// follows out_ready when a result is pending).
// Reset clears all valid flags and the count; no clearing pass is needed.
// A stalled result holds because the cells only change on an accepted request.

module ring_deque_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [31:0] data_in,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [6:0]  item_count_out,
	output logic [31:0] front_word,
	output logic [31:0] back_word
);

	localparam int DEPTH = rdq_pkg::DEPTH;
	localparam int DW    = rdq_pkg::DATA_WIDTH;
	localparam int CW    = rdq_pkg::CNT_W;

	logic                 in_fire;
	rdq_pkg::op_t         op_in;
	logic                 full;
	logic                 empty;
	rdq_pkg::cmd_t        cmd;
	rdq_pkg::status_t     status_d;
	rdq_pkg::status_t     status_q;
	logic [CW-1:0]        count_q;
	logic                 out_valid_q;
	logic [DEPTH-1:0]     valid_vec;
	logic [DW-1:0]        data_arr [DEPTH];
	logic [DW-1:0]        tap_arr  [DEPTH];
	logic [DW-1:0]        back_or;

	assign op_in    = rdq_pkg::op_t'(op);
	assign in_ready = !out_valid_q || out_ready;
	assign in_fire  = in_valid && in_ready;
	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);

	// decode the request into cell strobes
	always_comb begin
		cmd            = '0;
		cmd.word       = data_in[DW-1:0];
		status_d       = rdq_pkg::ST_DONE;
		case (op_in)
			rdq_pkg::OP_PUSH_BACK: begin
				if (full) status_d = rdq_pkg::ST_FULL;
				else      cmd.push_back = in_fire;
			end
			rdq_pkg::OP_PUSH_FRONT: begin
				if (full) status_d = rdq_pkg::ST_FULL;
				else      cmd.push_front = in_fire;
			end
			rdq_pkg::OP_POP_BACK: begin
				if (empty) status_d = rdq_pkg::ST_EMPTY;
				else       cmd.pop_back = in_fire;
			end
			rdq_pkg::OP_POP_FRONT: begin
				if (empty) status_d = rdq_pkg::ST_EMPTY;
				else       cmd.pop_front = in_fire;
			end
			default: begin
				status_d = rdq_pkg::ST_DONE;
			end
		endcase
	end

	// chain of cells, front at index 0
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic          lv;
		logic [DW-1:0] ld;
		logic          rv;
		logic [DW-1:0] rd;
		if (i == 0) begin : g_head
			assign lv = 1'b1;
			assign ld = data_in[DW-1:0];
		end else begin : g_mid_l
			assign lv = valid_vec[i-1];
			assign ld = data_arr[i-1];
		end
		if (i == DEPTH - 1) begin : g_tail
			assign rv = 1'b0;
			assign rd = '0;
		end else begin : g_mid_r
			assign rv = valid_vec[i+1];
			assign rd = data_arr[i+1];
		end
		rdq_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.left_valid (lv),
			.left_data  (ld),
			.right_valid(rv),
			.right_data (rd),
			.valid_q    (valid_vec[i]),
			.data_q     (data_arr[i]),
			.back_tap   (tap_arr[i])
		);
	end

	// collect the word of the last occupied cell
	always_comb begin
		back_or = '0;
		for (int k = 0; k < DEPTH; k++) begin
			back_or = back_or | tap_arr[k];
		end
	end

	// hold the count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.push_back || cmd.push_front) begin
			count_q <= count_q + 1'b1;
		end else if (cmd.pop_back || cmd.pop_front) begin
			count_q <= count_q - 1'b1;
		end
	end

	// result valid and status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			status_q    <= rdq_pkg::ST_DONE;
		end else if (in_fire) begin
			out_valid_q <= 1'b1;
			status_q    <= status_d;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign item_count_out = 7'(count_q);
	assign front_word     = 32'(valid_vec[0] ? data_arr[0] : '0);
	assign back_word      = 32'(back_or);

	// count tracks the occupied cells
	a_count_cells: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) == $countones(valid_vec))
		else $error("count differs from occupied cells");

	// occupied cells stay packed toward the front (a run of ones from bit 0)
	a_packed: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_vec & (valid_vec + 1'b1)) == '0)
		else $error("gap in occupied cells");

	// a refused push only when full
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q == rdq_pkg::ST_FULL |-> full)
		else $error("push refused while not full");

	// an empty removal leaves zero words showing
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q == rdq_pkg::ST_EMPTY |-> empty && front_word == '0
		&& back_word == '0)
		else $error("empty removal with words showing");

	// an accepted push with room grows the count by one
	a_grow: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && !full && (op_in == rdq_pkg::OP_PUSH_BACK || op_in == rdq_pkg::OP_PUSH_FRONT)
		|=> 32'(count_q) == 32'($past(count_q)) + 1)
		else $error("push did not grow count");

endmodule

/* tb/sv/testbench.sv */
// Testbench for the ring deque: random and directed requests checked against a local deque model.
`timescale 1ns / 1ps

module testbench;

	import rdq_pkg::*;

	localparam int CYCLE_LIMIT = 200000;

	typedef struct {
		op_t                   op;
		logic [DATA_WIDTH-1:0] word;
		int                    gap;
		bit                    hold;
		bit                    quiet;
	} request_t;

	typedef struct {
		status_t               status;
		logic [CNT_W-1:0]      count;
		logic [DATA_WIDTH-1:0] front;
		logic [DATA_WIDTH-1:0] back;
	} deque_view_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  op = OP_PUSH_BACK;
	logic [31:0] data_in = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  status;
	logic [6:0]  item_count_out;
	logic [31:0] front_word;
	logic [31:0] back_word;

	request_t    request_q[$];
	deque_view_t deque_view_q[$];

	// local copy of the deque
	logic [DATA_WIDTH-1:0] ring_copy[DEPTH];
	int                    head_idx = 0;
	int                    tail_idx = 0;
	int                    held = 0;

	// generator-side fill level, used to shape the sequences
	int gen_level = 0;

	int  fail_cnt = 0;
	int  gap_done = 0;
	int  stall_left = 0;
	int  cycle_cnt = 0;
	bit  calm = 1'b0;

	ring_deque_unit u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.op             (op),
		.data_in        (data_in),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.item_count_out (item_count_out),
		.front_word     (front_word),
		.back_word      (back_word)
	);

	always #5 clk = ~clk;

	// apply one request to the local deque and queue the view it should produce
	function automatic void predict_deque_op(op_t req_op, logic [DATA_WIDTH-1:0] word);
		deque_view_t view;
		view.status = ST_DONE;
		if (req_op == OP_PUSH_BACK || req_op == OP_PUSH_FRONT) begin
			if (held >= DEPTH) begin
				view.status = ST_FULL;
			end else if (req_op == OP_PUSH_BACK) begin
				ring_copy[tail_idx] = word;
				tail_idx = (tail_idx + 1) % DEPTH;
				held++;
			end else begin
				head_idx = (head_idx + DEPTH - 1) % DEPTH;
				ring_copy[head_idx] = word;
				held++;
			end
		end else begin
			if (held == 0) begin
				view.status = ST_EMPTY;
			end else begin
				if (req_op == OP_POP_BACK)
					tail_idx = (tail_idx + DEPTH - 1) % DEPTH;
				else
					head_idx = (head_idx + 1) % DEPTH;
				held--;
			end
		end
		view.count = held[CNT_W-1:0];
		if (held == 0) begin
			view.front = '0;
			view.back  = '0;
		end else begin
			view.front = ring_copy[head_idx];
			view.back  = ring_copy[(tail_idx + DEPTH - 1) % DEPTH];
		end
		deque_view_q.push_back(view);
	endfunction

	// random word, biased toward all zeros and all ones
	function automatic logic [DATA_WIDTH-1:0] pick_word();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	// queue one request and track the fill level it leaves
	function automatic void add_request(op_t req_op, logic [DATA_WIDTH-1:0] word, bit hold,
		bit quiet);
		request_t req;
		req.op    = req_op;
		req.word  = word;
		req.gap   = quiet ? 0 : $urandom_range(0, 13);
		req.hold  = hold;
		req.quiet = quiet;
		request_q.push_back(req);
		if (req_op == OP_PUSH_BACK || req_op == OP_PUSH_FRONT) begin
			if (gen_level < DEPTH)
				gen_level++;
		end else if (gen_level > 0) begin
			gen_level--;
		end
	endfunction

	// feed requests, honoring gaps and hold-offs, and predict each accepted one
	always @(posedge clk) begin : request_driver
		logic taken;
		if (arst_n) begin
			taken = in_valid && in_ready;
			if (taken)
				predict_deque_op(op_t'(op), data_in);
			if (!in_valid || taken) begin
				if (request_q.size() == 0) begin
					in_valid <= 1'b0;
				end else if (gap_done < request_q[0].gap) begin
					gap_done <= gap_done + 1;
					in_valid <= 1'b0;
				end else if (request_q[0].hold && (taken || deque_view_q.size() != 0)) begin
					in_valid <= 1'b0;
				end else begin
					in_valid <= 1'b1;
					op       <= request_q[0].op;
					data_in  <= request_q[0].word;
					calm     <= request_q[0].quiet;
					gap_done <= 0;
					void'(request_q.pop_front());
				end
			end
		end
	end

	// take results with random stalls and check each against the oldest prediction
	always @(posedge clk) begin : result_monitor
		int          wait_cycles;
		deque_view_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (deque_view_q.size() == 0) begin
					$error("result with no request outstanding");
					fail_cnt++;
				end else begin
					want = deque_view_q.pop_front();
					if (status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, status);
						fail_cnt++;
					end
					if (item_count_out !== want.count) begin
						$error("item_count_out: expected %0d, got %0d", want.count,
							item_count_out);
						fail_cnt++;
					end
					if (front_word !== want.front) begin
						$error("front_word: expected %h, got %h", want.front, front_word);
						fail_cnt++;
					end
					if (back_word !== want.back) begin
						$error("back_word: expected %h, got %h", want.back, back_word);
						fail_cnt++;
					end
				end
				wait_cycles = calm ? 0 : $urandom_range(0, 13);
				out_ready  <= (wait_cycles == 0);
				stall_left <= wait_cycles;
			end else if (!out_ready) begin
				if (stall_left <= 1)
					out_ready <= 1'b1;
				stall_left <= stall_left - 1;
			end
		end
	end

	// bound the run
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$error("run did not finish within %0d cycles", CYCLE_LIMIT);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin : stimulus
		int   kind;
		int   n;
		bit   quiet;
		bit   first;
		op_t  req_op;

		// directed: removals on empty, extreme words, every operation
		add_request(OP_POP_BACK, '1, 1'b0, 1'b1);
		add_request(OP_POP_FRONT, '0, 1'b0, 1'b1);
		add_request(OP_PUSH_BACK, '0, 1'b0, 1'b1);
		add_request(OP_PUSH_FRONT, '1, 1'b0, 1'b0);
		add_request(OP_POP_BACK, '0, 1'b0, 1'b0);
		add_request(OP_POP_BACK, '0, 1'b0, 1'b0);
		add_request(OP_POP_BACK, '1, 1'b0, 1'b0);
		add_request(OP_PUSH_FRONT, 32'h0000_0001, 1'b0, 1'b0);
		add_request(OP_PUSH_BACK, 32'hA5A5_A5A5, 1'b0, 1'b0);
		add_request(OP_PUSH_FRONT, 32'h5A5A_5A5A, 1'b0, 1'b1);
		add_request(OP_PUSH_BACK, 32'h8000_0000, 1'b0, 1'b1);
		add_request(OP_POP_FRONT, '1, 1'b0, 1'b0);
		add_request(OP_POP_FRONT, '0, 1'b0, 1'b0);
		add_request(OP_POP_BACK, '0, 1'b0, 1'b0);
		add_request(OP_POP_BACK, '0, 1'b0, 1'b0);
		add_request(OP_POP_FRONT, '0, 1'b0, 1'b0);

		// random sequences: fill to full and beyond, drain to empty, or mixed
		first = 1'b1;
		while (request_q.size() < 420) begin
			kind  = first ? 0 : $urandom_range(0, 3);
			quiet = ($urandom_range(0, 3) == 0);
			add_request(op_t'($urandom_range(0, 3)), pick_word(),
				first || ($urandom_range(0, 2) == 0), quiet);
			first = 1'b0;
			case (kind)
				0: begin
					while (gen_level < DEPTH)
						add_request($urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT,
							pick_word(), 1'b0, quiet);
					n = $urandom_range(1, 3);
					repeat (n)
						add_request($urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT,
							pick_word(), 1'b0, quiet);
				end
				1: begin
					while (gen_level > 0)
						add_request($urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT,
							pick_word(), 1'b0, quiet);
					n = $urandom_range(1, 2);
					repeat (n)
						add_request($urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT,
							pick_word(), 1'b0, quiet);
				end
				default: begin
					repeat (20) begin
						req_op = op_t'($urandom_range(0, 3));
						add_request(req_op, pick_word(), 1'b0, quiet);
					end
				end
			endcase
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// drain stimulus, then outstanding results, then a short tail
		while (request_q.size() != 0 || in_valid)
			@(posedge clk);
		while (deque_view_q.size() != 0)
			@(posedge clk);
		repeat (5) @(posedge clk);

		if (fail_cnt == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
